[rtl/core/av1sh_pkg.sv]
package av1sh_pkg;

	// one queued word: byte, end-of-header mark, drop mark for emulation bytes
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
		logic       skip;
	} item_t;

	localparam logic [7:0] EMU_BYTE   = 8'h03;
	localparam int         QUEUE_DEPTH = 4;

endpackage

[rtl/core/av1_sequence_header_parser_top.sv]
// Path: a byte accepted into an empty, idle block goes through the input queue, is loaded
// into the word register and walked bit by bit, and its result is set in the output register.
// Throughput: the parser takes one bit per cycle while it is not stalled; a dropped
// emulation byte is not walked bit by bit. The input queue holds 4 bytes; a result held by
// out_ready low stalls the parser at the end of the next byte that has a result.
// Reset (arst_n low, asynchronous): parser at the start of a header, queue empty,
// no result pending, strip_emulation_bytes set to 1.
module av1_sequence_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [2:0]  profile_code,
	output logic [4:0]  level_index,
	output logic        tier,
	output logic        delay_present,
	output logic [3:0]  delay_minus_one,
	output logic [4:0]  buffer_delay_bits_minus_one,
	output logic [16:0] max_width,
	output logic [16:0] max_height
);
	import av1sh_pkg::*;

	logic  q_valid, q_pop;
	item_t q_item;

	// accept and classify words
	av1sh_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .byte_value(byte_value),
		.last_byte(last_byte), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// parse bits and deliver results
	av1sh_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.profile_code(profile_code), .level_index(level_index), .tier(tier),
		.delay_present(delay_present), .delay_minus_one(delay_minus_one),
		.buffer_delay_bits_minus_one(buffer_delay_bits_minus_one),
		.max_width(max_width), .max_height(max_height)
	);

`ifndef NO_ASSERTIONS
	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> profile_code == 3'd0 && max_width == 17'd0 && max_height == 17'd0)
		else $error("truncated result carries nonzero fields");
	a_size_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> max_width != 17'd0 && max_height != 17'd0)
		else $error("complete result without frame size");
`endif

endmodule

[rtl/core/av1sh_front.sv]
module av1sh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_value,
	input  logic               last_byte,
	output logic               q_valid,
	output av1sh_pkg::item_t   q_item,
	input  logic               q_pop
);
	import av1sh_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic            strip_q;
	logic [1:0]      zero_run_q;
	item_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push, skip;

	assign in_ready = (count_q != PW'(0) + (PW+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
	assign push     = in_valid && in_ready;
	assign skip     = strip_q && (zero_run_q == 2'd2) && (byte_value == EMU_BYTE);
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	// hold the strip setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b1;
		end else if (cfg_we) begin
			strip_q <= cfg_wdata;
		end
	end

	// track the run of zero words, restart on end of header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= 2'd0;
		end else if (push) begin
			if (last_byte || skip || byte_value != 8'd0) begin
				zero_run_q <= 2'd0;
			end else if (zero_run_q != 2'd3) begin
				zero_run_q <= zero_run_q + 2'd1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{byte_value: byte_value, last_byte: last_byte, skip: skip};
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (q_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

endmodule

[rtl/core/av1sh_back.sv]
module av1sh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  av1sh_pkg::item_t  q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic [2:0]        profile_code,
	output logic [4:0]        level_index,
	output logic              tier,
	output logic              delay_present,
	output logic [3:0]        delay_minus_one,
	output logic [4:0]        buffer_delay_bits_minus_one,
	output logic [16:0]       max_width,
	output logic [16:0]       max_height
);
	import av1sh_pkg::*;

	typedef enum logic [34:0] {
		PH_PROFILE      = 35'd1 << 0,
		PH_STILL_RED    = 35'd1 << 1,
		PH_LEVEL_RED    = 35'd1 << 2,
		PH_TIMING       = 35'd1 << 3,
		PH_UNITS        = 35'd1 << 4,
		PH_SCALE_EQ     = 35'd1 << 5,
		PH_UVLC_PREFIX  = 35'd1 << 6,
		PH_UVLC_VALUE   = 35'd1 << 7,
		PH_DM_PRESENT   = 35'd1 << 8,
		PH_BDL          = 35'd1 << 9,
		PH_DM_REST      = 35'd1 << 10,
		PH_IPD_PRESENT  = 35'd1 << 11,
		PH_OP_COUNT     = 35'd1 << 12,
		PH_OP_IDC       = 35'd1 << 13,
		PH_OP_LEVEL     = 35'd1 << 14,
		PH_OP_TIER      = 35'd1 << 15,
		PH_OP_DM        = 35'd1 << 16,
		PH_OP_DEC       = 35'd1 << 17,
		PH_OP_ENC_LOW   = 35'd1 << 18,
		PH_OP_IDD_PRES  = 35'd1 << 19,
		PH_OP_IDD       = 35'd1 << 20,
		PH_FW_BITS      = 35'd1 << 21,
		PH_FH_BITS      = 35'd1 << 22,
		PH_WIDTH        = 35'd1 << 23,
		PH_HEIGHT       = 35'd1 << 24,
		PH_FRAME_ID     = 35'd1 << 25,
		PH_FRAME_ID_LEN = 35'd1 << 26,
		PH_TOOLS        = 35'd1 << 27,
		PH_TOOLS_RED    = 35'd1 << 28,
		PH_OH_TAIL      = 35'd1 << 29,
		PH_FORCE_SCT    = 35'd1 << 30,
		PH_CHOOSE_IMV   = 35'd1 << 31,
		PH_FORCE_IMV    = 35'd1 << 32,
		PH_OH_BITS      = 35'd1 << 33,
		PH_FINAL        = 35'd1 << 34
	} phase_t;

	// current word
	logic        busy_q, skip_q, last_q, was_done_q;
	logic [7:0]  sh_q;
	logic [2:0]  cnt_q;
	// parser state
	phase_t      ph_q, n_ph;
	logic [5:0]  fbl_q, n_fbl, fbl_dec;
	logic [31:0] acc_q, n_acc, acc_new;
	logic [4:0]  op_idx_q, n_op_idx, op_cnt_q, n_op_cnt;
	logic        red_q, dm_q, ipd_q, oh_q, n_red, n_dm, n_ipd, n_oh;
	logic [3:0]  wb_q, hb_q, n_wb, n_hb;
	logic [2:0]  prof_q, n_prof;
	logic [4:0]  lvl_q, n_lvl, bdl_q, n_bdl;
	logic        tier_q, n_tier, dpres_q, n_dpres, done_q, n_done;
	logic [3:0]  dly_q, n_dly;
	logic [16:0] wid_q, n_wid, hgt_q, n_hgt;
	// control
	logic        b, proc, fin, emit0, emit1, adv, out_valid_q;
	logic        res_status;

	assign b    = sh_q[7];
	assign proc = busy_q && !skip_q && !done_q;
	assign fin  = busy_q && (skip_q || cnt_q == 3'd7);

	// walk one header bit
	always_comb begin
		n_ph = ph_q; n_fbl = fbl_q; n_acc = acc_q;
		n_op_idx = op_idx_q; n_op_cnt = op_cnt_q;
		n_red = red_q; n_dm = dm_q; n_ipd = ipd_q; n_oh = oh_q;
		n_wb = wb_q; n_hb = hb_q;
		n_prof = prof_q; n_lvl = lvl_q; n_bdl = bdl_q; n_tier = tier_q;
		n_dpres = dpres_q; n_dly = dly_q; n_wid = wid_q; n_hgt = hgt_q;
		n_done = done_q;
		acc_new = {acc_q[30:0], b};
		fbl_dec = (fbl_q != 6'd0) ? fbl_q - 6'd1 : 6'd0;
		if (proc) begin
			if (ph_q == PH_UVLC_PREFIX) begin
				if (!b) begin
					if (fbl_q < 6'd32) n_fbl = fbl_q + 6'd1;
				end else if (fbl_q == 6'd0 || fbl_q >= 6'd32) begin
					n_ph = PH_DM_PRESENT; n_fbl = 6'd1; n_acc = '0;
				end else begin
					n_ph = PH_UVLC_VALUE; n_acc = '0;
				end
			end else begin
				n_acc = acc_new;
				n_fbl = fbl_dec;
				if (fbl_dec == 6'd0) begin
					n_acc = '0;
					case (ph_q)
						PH_PROFILE: begin
							n_prof = acc_new[2:0]; n_ph = PH_STILL_RED; n_fbl = 6'd2;
						end
						PH_STILL_RED: begin
							if (b) begin
								n_red = 1'b1; n_ph = PH_LEVEL_RED; n_fbl = 6'd5;
							end else begin
								n_ph = PH_TIMING; n_fbl = 6'd1;
							end
						end
						PH_LEVEL_RED: begin
							n_lvl = acc_new[4:0]; n_ph = PH_FW_BITS; n_fbl = 6'd4;
						end
						PH_TIMING: begin
							if (b) begin
								n_ph = PH_UNITS; n_fbl = 6'd32;
							end else begin
								n_ph = PH_IPD_PRESENT; n_fbl = 6'd1;
							end
						end
						PH_UNITS: begin
							n_ph = PH_SCALE_EQ; n_fbl = 6'd33;
						end
						PH_SCALE_EQ: begin
							if (b) begin
								n_ph = PH_UVLC_PREFIX; n_fbl = 6'd0;
							end else begin
								n_ph = PH_DM_PRESENT; n_fbl = 6'd1;
							end
						end
						PH_UVLC_VALUE: begin
							n_ph = PH_DM_PRESENT; n_fbl = 6'd1;
						end
						PH_DM_PRESENT: begin
							if (b) begin
								n_dm = 1'b1; n_ph = PH_BDL; n_fbl = 6'd5;
							end else begin
								n_ph = PH_IPD_PRESENT; n_fbl = 6'd1;
							end
						end
						PH_BDL: begin
							n_bdl = acc_new[4:0]; n_ph = PH_DM_REST; n_fbl = 6'd42;
						end
						PH_DM_REST: begin
							n_ph = PH_IPD_PRESENT; n_fbl = 6'd1;
						end
						PH_IPD_PRESENT: begin
							n_ipd = ipd_q | b; n_dpres = b;
							n_ph = PH_OP_COUNT; n_fbl = 6'd5;
						end
						PH_OP_COUNT: begin
							n_op_cnt = acc_new[4:0]; n_op_idx = '0;
							n_ph = PH_OP_IDC; n_fbl = 6'd12;
						end
						PH_OP_IDC: begin
							n_ph = PH_OP_LEVEL; n_fbl = 6'd5;
						end
						PH_OP_LEVEL: begin
							if (op_idx_q == 5'd0) begin
								n_lvl = acc_new[4:0]; n_tier = 1'b0;
							end
							if (acc_new[4:0] > 5'd7) begin
								n_ph = PH_OP_TIER; n_fbl = 6'd1;
							end else if (dm_q) begin
								n_ph = PH_OP_DM; n_fbl = 6'd1;
							end else if (ipd_q) begin
								n_ph = PH_OP_IDD_PRES; n_fbl = 6'd1;
							end else if (op_idx_q >= op_cnt_q) begin
								n_ph = PH_FW_BITS; n_fbl = 6'd4;
							end else begin
								n_op_idx = op_idx_q + 5'd1; n_ph = PH_OP_IDC; n_fbl = 6'd12;
							end
						end
						PH_OP_TIER: begin
							if (op_idx_q == 5'd0) n_tier = b;
							if (dm_q) begin
								n_ph = PH_OP_DM; n_fbl = 6'd1;
							end else if (ipd_q) begin
								n_ph = PH_OP_IDD_PRES; n_fbl = 6'd1;
							end else if (op_idx_q >= op_cnt_q) begin
								n_ph = PH_FW_BITS; n_fbl = 6'd4;
							end else begin
								n_op_idx = op_idx_q + 5'd1; n_ph = PH_OP_IDC; n_fbl = 6'd12;
							end
						end
						PH_OP_DM, PH_OP_ENC_LOW: begin
							if (ph_q == PH_OP_DM && b) begin
								n_ph = PH_OP_DEC; n_fbl = {1'b0, bdl_q} + 6'd1;
							end else if (ipd_q) begin
								n_ph = PH_OP_IDD_PRES; n_fbl = 6'd1;
							end else if (op_idx_q >= op_cnt_q) begin
								n_ph = PH_FW_BITS; n_fbl = 6'd4;
							end else begin
								n_op_idx = op_idx_q + 5'd1; n_ph = PH_OP_IDC; n_fbl = 6'd12;
							end
						end
						PH_OP_DEC: begin
							n_ph = PH_OP_ENC_LOW; n_fbl = {1'b0, bdl_q} + 6'd2;
						end
						PH_OP_IDD_PRES, PH_OP_IDD: begin
							if (ph_q == PH_OP_IDD_PRES && b) begin
								n_ph = PH_OP_IDD; n_fbl = 6'd4;
							end else begin
								if (ph_q == PH_OP_IDD && op_idx_q == 5'd0) n_dly = acc_new[3:0];
								if (op_idx_q >= op_cnt_q) begin
									n_ph = PH_FW_BITS; n_fbl = 6'd4;
								end else begin
									n_op_idx = op_idx_q + 5'd1; n_ph = PH_OP_IDC; n_fbl = 6'd12;
								end
							end
						end
						PH_FW_BITS: begin
							n_wb = acc_new[3:0]; n_ph = PH_FH_BITS; n_fbl = 6'd4;
						end
						PH_FH_BITS: begin
							n_hb = acc_new[3:0]; n_ph = PH_WIDTH; n_fbl = {2'b00, wb_q} + 6'd1;
						end
						PH_WIDTH: begin
							n_wid = {1'b0, acc_new[15:0]} + 17'd1;
							n_ph = PH_HEIGHT; n_fbl = {2'b00, hb_q} + 6'd1;
						end
						PH_HEIGHT: begin
							n_hgt = {1'b0, acc_new[15:0]} + 17'd1;
							if (red_q) begin
								n_ph = PH_TOOLS_RED; n_fbl = 6'd6;
							end else begin
								n_ph = PH_FRAME_ID; n_fbl = 6'd1;
							end
						end
						PH_FRAME_ID: begin
							n_ph = b ? PH_FRAME_ID_LEN : PH_TOOLS; n_fbl = b ? 6'd7 : 6'd8;
						end
						PH_FRAME_ID_LEN: begin
							n_ph = PH_TOOLS; n_fbl = 6'd8;
						end
						PH_TOOLS: begin
							n_oh = oh_q | b; n_ph = PH_OH_TAIL; n_fbl = b ? 6'd3 : 6'd1;
						end
						PH_OH_TAIL: begin
							n_ph = b ? PH_CHOOSE_IMV : PH_FORCE_SCT; n_fbl = 6'd1;
						end
						PH_FORCE_SCT: begin
							if (b) begin
								n_ph = PH_CHOOSE_IMV; n_fbl = 6'd1;
							end else begin
								n_ph = oh_q ? PH_OH_BITS : PH_FINAL; n_fbl = 6'd3;
							end
						end
						PH_CHOOSE_IMV: begin
							if (b) begin
								n_ph = oh_q ? PH_OH_BITS : PH_FINAL; n_fbl = 6'd3;
							end else begin
								n_ph = PH_FORCE_IMV; n_fbl = 6'd1;
							end
						end
						PH_FORCE_IMV: begin
							n_ph = oh_q ? PH_OH_BITS : PH_FINAL; n_fbl = 6'd3;
						end
						PH_OH_BITS: begin
							n_ph = PH_FINAL; n_fbl = 6'd3;
						end
						default: begin
							n_done = 1'b1;
						end
					endcase
				end
			end
		end
	end

	// decide on a result at the end of the word
	assign emit0      = !was_done_q && n_done;
	assign emit1      = last_q && !n_done;
	assign res_status = !emit0;
	assign adv        = !(fin && (emit0 || emit1) && out_valid_q && !out_ready);
	assign q_pop      = q_valid && (!busy_q || (fin && adv));

	// word sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= 3'd0;
			was_done_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q     <= 1'b1;
				cnt_q      <= 3'd0;
				was_done_q <= (fin && last_q) ? 1'b0 : n_done;
			end else if (fin && adv) begin
				busy_q <= 1'b0;
			end else if (busy_q && adv) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sh_q   <= q_item.byte_value;
			last_q <= q_item.last_byte;
			skip_q <= q_item.skip;
		end else if (busy_q && adv) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

	// parser state, restart at end of header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_PROFILE; fbl_q <= 6'd3; acc_q <= '0;
			op_idx_q <= '0; op_cnt_q <= '0;
			red_q <= 1'b0; dm_q <= 1'b0; ipd_q <= 1'b0; oh_q <= 1'b0;
			wb_q <= '0; hb_q <= '0; prof_q <= '0; lvl_q <= '0; bdl_q <= '0;
			tier_q <= 1'b0; dpres_q <= 1'b0; dly_q <= '0; wid_q <= '0; hgt_q <= '0;
			done_q <= 1'b0;
		end else if (fin && adv && last_q) begin
			ph_q <= PH_PROFILE; fbl_q <= 6'd3; acc_q <= '0;
			op_idx_q <= '0; op_cnt_q <= '0;
			red_q <= 1'b0; dm_q <= 1'b0; ipd_q <= 1'b0; oh_q <= 1'b0;
			wb_q <= '0; hb_q <= '0; prof_q <= '0; lvl_q <= '0; bdl_q <= '0;
			tier_q <= 1'b0; dpres_q <= 1'b0; dly_q <= '0; wid_q <= '0; hgt_q <= '0;
			done_q <= 1'b0;
		end else if (adv) begin
			ph_q <= n_ph; fbl_q <= n_fbl; acc_q <= n_acc;
			op_idx_q <= n_op_idx; op_cnt_q <= n_op_cnt;
			red_q <= n_red; dm_q <= n_dm; ipd_q <= n_ipd; oh_q <= n_oh;
			wb_q <= n_wb; hb_q <= n_hb; prof_q <= n_prof; lvl_q <= n_lvl; bdl_q <= n_bdl;
			tier_q <= n_tier; dpres_q <= n_dpres; dly_q <= n_dly; wid_q <= n_wid;
			hgt_q <= n_hgt; done_q <= n_done;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin && adv && (emit0 || emit1)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && adv && (emit0 || emit1)) begin
			status                      <= res_status;
			profile_code                <= res_status ? 3'd0  : n_prof;
			level_index                 <= res_status ? 5'd0  : n_lvl;
			tier                        <= res_status ? 1'b0  : n_tier;
			delay_present               <= res_status ? 1'b0  : n_dpres;
			delay_minus_one             <= res_status ? 4'd0  : n_dly;
			buffer_delay_bits_minus_one <= res_status ? 5'd0  : n_bdl;
			max_width                   <= res_status ? 17'd0 : n_wid;
			max_height                  <= res_status ? 17'd0 : n_hgt;
		end
	end

	assign out_valid = out_valid_q;

endmodule
